@@ hdl/rotation_matrix_to_euler_top_macros.svh @@
// Assertion macros for the rotation matrix to Euler block.
// Included by modules that check their own pipeline behavior.
`ifndef ROTATION_MATRIX_TO_EULER_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_TOP_MACROS_SVH
`ifndef SYNTH
`define RME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define RME_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define RME_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RME_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/rme_pkg.sv @@
// Shared types and constants for the rotation matrix to Euler block.
// No dependencies.
package rme_pkg;
	localparam int TabLen = 24;
	localparam int DataW  = 38;
	localparam int AngW   = 33;
	localparam logic signed [AngW-1:0] AngPi = 33'sd1686629713;
	localparam logic [15:0] InvGain = 16'd39797;
	localparam logic signed [15:0] OutPi = 16'sd25736;
	localparam logic signed [15:0] OutHalfPi = 16'sd12868;

	typedef logic signed [DataW-1:0] data_t;
	typedef logic signed [AngW-1:0] ang_t;

	function automatic ang_t atan_tab(input int i);
		ang_t t;
		unique case (i)
			0: t = 33'sd421657428;  1: t = 33'sd248918915;
			2: t = 33'sd131521918;  3: t = 33'sd66762579;
			4: t = 33'sd33510843;   5: t = 33'sd16771758;
			6: t = 33'sd8387925;    7: t = 33'sd4194219;
			8: t = 33'sd2097141;    9: t = 33'sd1048575;
			10: t = 33'sd524288;    11: t = 33'sd262144;
			12: t = 33'sd131072;    13: t = 33'sd65536;
			14: t = 33'sd32768;     15: t = 33'sd16384;
			16: t = 33'sd8192;      17: t = 33'sd4096;
			18: t = 33'sd2048;      19: t = 33'sd1024;
			20: t = 33'sd512;       21: t = 33'sd256;
			22: t = 33'sd128;       default: t = 33'sd64;
		endcase
		return t;
	endfunction

	// round to nearest (ties up) and clamp to +-lim
	function automatic logic signed [15:0] to_out(input ang_t z, input logic signed [15:0] lim);
		logic signed [AngW:0] s;
		logic signed [AngW-16:0] a;
		s = {z[AngW-1], z} + (AngW+1)'(32768);
		a = s[AngW:16];
		if (a > 18'(lim)) return lim;
		if (a < -18'(lim)) return -lim;
		return a[15:0];
	endfunction
endpackage

@@ hdl/rme_cordic.sv @@
// Pipelined CORDIC vectoring lane: one stage per iteration, one vector per cycle while en is high.
// Depends on rme_pkg.
module rme_cordic #(
	parameter int Steps = 16
) (
	input  logic            clk,
	input  logic            en,
	input  rme_pkg::data_t  x_in,
	input  rme_pkg::data_t  y_in,
	output rme_pkg::data_t  x_out,
	output rme_pkg::ang_t   z_out
);
	localparam int N = (Steps > rme_pkg::TabLen) ? rme_pkg::TabLen : Steps;

	rme_pkg::data_t x_q [N+1];
	rme_pkg::data_t y_q [N+1];
	rme_pkg::ang_t  z_q [N+1];
	logic           zero_q [N+1];

	// stage 0: fold the left half-plane
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x_q[0] <= -x_in;
				y_q[0] <= -y_in;
				z_q[0] <= (y_in >= 0) ? rme_pkg::AngPi : -rme_pkg::AngPi;
			end else begin
				x_q[0] <= x_in;
				y_q[0] <= y_in;
				z_q[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				zero_q[i+1] <= zero_q[i];
				if (y_q[i] > 0) begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + rme_pkg::atan_tab(i);
				end else begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - rme_pkg::atan_tab(i);
				end
			end
		end
	end

	assign x_out = zero_q[N] ? '0 : x_q[N];
	assign z_out = zero_q[N] ? '0 : z_q[N];
endmodule

@@ hdl/rme_merge.sv @@
// Merge stage: gain-compensate the roll magnitude and negate and scale m20 for the pitch lane.
// Depends on rme_pkg.
module rme_merge (
	input  logic                clk,
	input  logic                en,
	input  rme_pkg::data_t      xr,
	input  logic signed [15:0]  m20,
	output rme_pkg::data_t      mag,
	output rme_pkg::data_t      ny
);
	localparam int DW = rme_pkg::DataW + 17;
	logic signed [DW:0] prod_s1;
	logic signed [15:0] m20_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (DW+1)'(xr) * (DW+1)'($signed({1'b0, rme_pkg::InvGain}))
				+ (DW+1)'(32768);
			m20_s1  <= m20;
		end
	end

	assign mag = prod_s1[rme_pkg::DataW+15:16];
	assign ny  = -(rme_pkg::DataW'(m20_s1) <<< 14);
endmodule

@@ hdl/rotation_matrix_to_euler_top.sv @@
// Top level: rotation matrix to ZYX Euler angles.
// Depends on rme_pkg, rme_cordic, rme_merge and the macros header.
//
// Usage:
//  s_axis carries one 3x3 rotation matrix per beat, elements in Q2.14:
//   tdata = {m22, m21, m20, m10, m00}, m00 in bits 15:0, 16 bits each.
//  m_axis returns one beat per matrix: tdata = {pad, roll, pitch, yaw}:
//   yaw [15:0], pitch [30:16], roll [46:31], zero padded to 48 bits, Q3.13 rad (pitch Q2.13).
// Two CORDIC lanes (yaw, roll) run in parallel; a merge stage compensates the
// roll magnitude, a third lane computes pitch from it, and an output stage
// rounds and clamps all three angles.
// N = min(CORDIC_STEPS, 24) iterations per lane; one matrix per cycle unless held.
// The pipeline advances as one unit: it holds whenever the output register is
// full and m_axis_tready is low, so s_axis_tready drops with it.
// Reset clears only the valid bits; no result exists until a matrix enters.
`include "rotation_matrix_to_euler_top_macros.svh"
module rotation_matrix_to_euler_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // m00, m10, m20, m21, m22
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // yaw, pitch, roll, pad
);
	localparam int N   = (CORDIC_STEPS > rme_pkg::TabLen) ? rme_pkg::TabLen : CORDIC_STEPS;
	localparam int Lat = 2 * (N + 1) + 2;

	logic en;
	logic [Lat-1:0] vld_q;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[Lat-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
		end
	end

	rme_pkg::data_t xr, xy_unused, xp_unused, mag, ny;
	rme_pkg::ang_t  zy, zr, zp;
	logic signed [15:0] m20_d [N+1];
	rme_pkg::ang_t zy_d [N+2];
	rme_pkg::ang_t zr_d [N+2];

	rme_cordic #(.Steps(CORDIC_STEPS)) u_yaw (.clk, .en,
		.x_in(rme_pkg::DataW'($signed(s_axis_tdata[15:0])) <<< 14),
		.y_in(rme_pkg::DataW'($signed(s_axis_tdata[31:16])) <<< 14),
		.x_out(xy_unused), .z_out(zy));
	rme_cordic #(.Steps(CORDIC_STEPS)) u_roll (.clk, .en,
		.x_in(rme_pkg::DataW'($signed(s_axis_tdata[79:64])) <<< 14),
		.y_in(rme_pkg::DataW'($signed(s_axis_tdata[63:48])) <<< 14),
		.x_out(xr), .z_out(zr));

	// delay m20 to meet the roll magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			m20_d[0] <= $signed(s_axis_tdata[47:32]);
			for (int k = 1; k <= N; k++) m20_d[k] <= m20_d[k-1];
		end
	end

	rme_merge u_merge (.clk, .en, .xr, .m20(m20_d[N]), .mag, .ny);

	rme_cordic #(.Steps(CORDIC_STEPS)) u_pitch (.clk, .en,
		.x_in(mag), .y_in(ny), .x_out(xp_unused), .z_out(zp));

	// align yaw and roll with pitch
	always_ff @(posedge clk) begin
		if (en) begin
			zy_d[0] <= zy;
			zr_d[0] <= zr;
			for (int k = 1; k <= N+1; k++) begin
				zy_d[k] <= zy_d[k-1];
				zr_d[k] <= zr_d[k-1];
			end
		end
	end

	logic signed [15:0] yaw_q, pitch_w, roll_q, pitch_q;
	assign pitch_w = rme_pkg::to_out(zp, rme_pkg::OutHalfPi);
	always_ff @(posedge clk) begin
		if (en) begin
			yaw_q   <= rme_pkg::to_out(zy_d[N+1], rme_pkg::OutPi);
			roll_q  <= rme_pkg::to_out(zr_d[N+1], rme_pkg::OutPi);
			pitch_q <= pitch_w;
		end
	end

	assign m_axis_tdata = {1'b0, roll_q, pitch_q[14:0], yaw_q};

	`RME_ASSERT_IMP(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
	`RME_ASSERT_NXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`RME_ASSERT_IMP(a_yaw_rng, clk, arst_n, m_axis_tvalid, yaw_q <= rme_pkg::OutPi && yaw_q >= -rme_pkg::OutPi)
endmodule

@@ test/euler_checker.sv @@
`timescale 1ns / 1ps
// Stream monitor for the rotation matrix to Euler block: predicts angles per matrix beat
// and compares each output beat against the oldest prediction. Depends on nothing else.
module euler_checker #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [79:0] in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [47:0] out_data,
	output int          errors,
	output int          pending,
	output int          matched
);
	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
	} angles_t;

	localparam longint AngPi = 64'sd1686629713;
	localparam longint InvGain = 64'sd39797;
	localparam longint LimPi = 64'sd25736;
	localparam longint LimHalfPi = 64'sd12868;

	angles_t expected_angles[$];

	function automatic longint atan_step(input int i);
		longint t[24] = '{421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
			8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536, 32768,
			16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64};
		return t[i];
	endfunction

	// Vectoring rotation; returns angle in 2^-29 rad, final x in mag.
	function automatic longint vector_angle(input longint x0, input longint y0,
			output longint mag);
		longint x, y, z, dx, dy;
		x = x0;
		y = y0;
		z = 0;
		mag = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? AngPi : -AngPi;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += atan_step(i);
			end else begin
				x -= dx;
				y += dy;
				z -= atan_step(i);
			end
		end
		mag = x;
		return z;
	endfunction

	function automatic longint round_clamp(input longint z, input longint lim);
		longint a;
		a = (z + 32768) >>> 16;
		if (a > lim) a = lim;
		if (a < -lim) a = -lim;
		return a;
	endfunction

	function automatic angles_t euler_of(input logic [79:0] d);
		longint m00, m10, m20, m21, m22, xr, mag, dummy, zy, zp, zr;
		angles_t r;
		m00 = longint'($signed(d[15:0])) * 16384;
		m10 = longint'($signed(d[31:16])) * 16384;
		m20 = longint'($signed(d[47:32])) * 16384;
		m21 = longint'($signed(d[63:48])) * 16384;
		m22 = longint'($signed(d[79:64])) * 16384;
		zy = vector_angle(m00, m10, dummy);
		zr = vector_angle(m22, m21, xr);
		mag = (xr * InvGain + 32768) >>> 16;
		zp = vector_angle(mag, -m20, dummy);
		r.yaw = 16'(round_clamp(zy, LimPi));
		r.pitch = 15'(round_clamp(zp, LimHalfPi));
		r.roll = 16'(round_clamp(zr, LimPi));
		return r;
	endfunction

	always @(posedge clk) begin
		angles_t got, want;
		if (!arst_n) begin
			errors = 0;
			matched = 0;
			expected_angles.delete();
		end else begin
			if (in_valid && in_ready) expected_angles.push_back(euler_of(in_data));
			if (out_valid && out_ready) begin
				got = out_data[46:0];
				if (expected_angles.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, got %h", $time, got);
				end else begin
					want = expected_angles.pop_front();
					matched++;
					if (got.yaw !== want.yaw || got.pitch !== want.pitch
							|| got.roll !== want.roll || out_data[47] !== 1'b0) begin
						errors++;
						$display("%0t: mismatch yaw/pitch/roll exp %0d %0d %0d got %0d %0d %0d",
							$time, want.yaw, want.pitch, want.roll,
							got.yaw, got.pitch, got.roll);
					end
				end
			end
		end
		pending = expected_angles.size();
	end
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Top of the testbench: drives matrices into the block with random gaps and a long
// output stall, instantiates the block and euler_checker, and prints the verdict.
module tb;
	localparam int Latency = 2 * 17 + 2;
	localparam int WatchLimit = 2000;
	localparam int RandItems = 2000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;   // m00, m10, m20, m21, m22
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // yaw, pitch, roll, pad
	int          errors, pending, matched, idle_cycles, sent;

	rotation_matrix_to_euler_top u_dut (.*);

	euler_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
		.errors(errors), .pending(pending), .matched(matched)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Random Q2.14 element: mostly near unit range, sometimes a full-scale extreme or any 16-bit value.
	function automatic logic [15:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// Hand one matrix beat over; hold valid until accepted, then drop valid for a random gap unless no_gap is set.
	task automatic send_matrix(input logic [15:0] m00, m10, m20, m21, m22,
			input bit no_gap);
		int gap;
		s_axis_tdata  <= {m22, m21, m20, m10, m00};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
		gap = no_gap ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Receiver: random stall per beat but none in a window, one long stall mid-run while the sender keeps going.
	initial begin
		int stall;
		bit held;
		held = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && sent > 800) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			stall = (matched > 1200 && matched < 1500) ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Watchdog on handshake activity.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("tb: timeout at %0t", $time);
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		logic [15:0] ext[6];
		ext = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000, 16'hc000, 16'h0001};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: both operands zero, extremes, left half-plane, negated most negative m20.
		send_matrix(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
		send_matrix(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 0);
		send_matrix(16'h8000, 16'h0000, 16'h8000, 16'h0000, 16'h8000, 0);
		send_matrix(16'h8000, 16'hffff, 16'h7fff, 16'hffff, 16'h8000, 0);
		send_matrix(16'h0000, 16'h4000, 16'h4000, 16'h0000, 16'h0000, 0);
		send_matrix(16'h0000, 16'hc000, 16'hc000, 16'hc000, 16'h0000, 0);
		send_matrix(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 0);
		send_matrix(16'hffff, 16'h0000, 16'h0001, 16'h0000, 16'hffff, 0);
		foreach (ext[i])
			send_matrix(ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6], ext[(i + 3) % 6],
				ext[(i + 4) % 6], 0);
		send_matrix(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0);
		for (int n = 0; n < RandItems; n++) begin
			send_matrix(rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
				n > 800 && n < 1000);
		end
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (Latency + 10) @(posedge clk);
		$display("tb: %0d matrices sent, %0d angle beats checked, incl. zero, extreme",
			sent, matched);
		$display("tb: and left half-plane cases, random gaps and a long output stall");
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
